FILE: hw/rtl/spsu_pkg.sv
`timescale 1ns / 1ps

package spsu_pkg;

    localparam int COORD_W = 32;
    localparam int NORM_W  = 16;
    localparam int EPS_W   = 16;
    localparam int FRAC_N  = 14;
    localparam int PROD_W  = COORD_W + NORM_W;
    localparam int DIST_W  = 50;
    localparam int DIFF_W  = DIST_W + 1;
    localparam int DELTA_W = COORD_W + 1;
    localparam int MAG_W   = DIST_W;
    localparam int DEN_W   = DIST_W;
    localparam int Q_W     = COORD_W;
    localparam int LO_W    = 25;
    localparam int HI_W    = MAG_W - LO_W;
    localparam int PART_W  = Q_W + LO_W;
    localparam int DVD_W   = Q_W + MAG_W;
    localparam int REM_W   = DEN_W + 1;

    localparam logic signed [NORM_W-1:0]  NORM_ONE  = 16'sd16384;
    localparam logic signed [NORM_W-1:0]  NORM_MONE = -16'sd16384;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic [EPS_W-1:0]          EPS_RESET = 16'd13107;

    localparam logic [1:0] SIDE_ON    = 2'd0;
    localparam logic [1:0] SIDE_FRONT = 2'd1;
    localparam logic [1:0] SIDE_BACK  = 2'd2;

    localparam logic [1:0] CLS_ON    = 2'd0;
    localparam logic [1:0] CLS_FRONT = 2'd1;
    localparam logic [1:0] CLS_BACK  = 2'd2;
    localparam logic [1:0] CLS_CROSS = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic signed [NORM_W-1:0]  nx;
        logic signed [NORM_W-1:0]  ny;
        logic signed [COORD_W-1:0] off;
        logic [1:0]                s0;
        logic [1:0]                s1;
        logic                      negx;
        logic                      negy;
    } t_meta;

endpackage

FILE: hw/rtl/segment_plane_split_unit.sv
`timescale 1ns / 1ps
// Channel   | Direction | Signals
// ----------+-----------+----------------------------------------------------
// segment   | in        | i_valid, o_stall, i_start_*, i_end_*, i_normal_*, ...
// result    | out       | o_valid, i_stall, o_segment_class, o_has_*, o_front_*
// epsilon   | in        | i_side_epsilon_we, i_side_epsilon
//
// One transaction enters per cycle unless stalled; stages are products, distance sum,
// classification, split multiply, multiply sum, 32 restoring divider stages, output.
// The 32-stage divider, one quotient bit per stage, sets the depth.
// Synchronous active-low reset clears all valid bits and restores the epsilon.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
module segment_plane_split_unit
    import spsu_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_side_epsilon_we,
    input  logic [EPS_W-1:0]          i_side_epsilon,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [COORD_W-1:0] i_start_x,
    input  logic signed [COORD_W-1:0] i_start_y,
    input  logic signed [COORD_W-1:0] i_end_x,
    input  logic signed [COORD_W-1:0] i_end_y,
    input  logic signed [NORM_W-1:0]  i_normal_x,
    input  logic signed [NORM_W-1:0]  i_normal_y,
    input  logic signed [COORD_W-1:0] i_line_offset,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [1:0]                o_segment_class,
    output logic                      o_has_front,
    output logic                      o_has_back,
    output logic signed [COORD_W-1:0] o_front_start_x,
    output logic signed [COORD_W-1:0] o_front_start_y,
    output logic signed [COORD_W-1:0] o_front_end_x,
    output logic signed [COORD_W-1:0] o_front_end_y,
    output logic signed [COORD_W-1:0] o_back_start_x,
    output logic signed [COORD_W-1:0] o_back_start_y,
    output logic signed [COORD_W-1:0] o_back_end_x,
    output logic signed [COORD_W-1:0] o_back_end_y
);

    logic adv;
    logic [EPS_W-1:0] r_eps;

    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (i_side_epsilon_we) begin
            r_eps <= i_side_epsilon;
        end
    end

    // Stage A: endpoint products.
    logic                     r_va;
    t_meta                    r_ma;
    logic signed [PROD_W-1:0] r_pxs, r_pys, r_pxe, r_pye;
    t_meta                    n_ma;

    always_comb begin
        n_ma      = '0;
        n_ma.sx   = i_start_x;
        n_ma.sy   = i_start_y;
        n_ma.ex   = i_end_x;
        n_ma.ey   = i_end_y;
        n_ma.nx   = i_normal_x;
        n_ma.ny   = i_normal_y;
        n_ma.off  = i_line_offset;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (adv) begin
            r_va <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ma  <= n_ma;
            r_pxs <= i_normal_x * i_start_x;
            r_pys <= i_normal_y * i_start_y;
            r_pxe <= i_normal_x * i_end_x;
            r_pye <= i_normal_y * i_end_y;
        end
    end

    // Stage B: distances and deltas.
    logic                      r_vb;
    t_meta                     r_mb;
    logic signed [DIST_W-1:0]  r_d0, r_d1;
    logic signed [DELTA_W-1:0] r_dx, r_dy;
    logic signed [DIST_W-1:0]  n_offs;

    assign n_offs = DIST_W'(r_ma.off) <<< FRAC_N;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (adv) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mb <= r_ma;
            r_d0 <= DIST_W'(r_pxs) + DIST_W'(r_pys) + n_offs;
            r_d1 <= DIST_W'(r_pxe) + DIST_W'(r_pye) + n_offs;
            r_dx <= DELTA_W'(r_ma.ex) - DELTA_W'(r_ma.sx);
            r_dy <= DELTA_W'(r_ma.ey) - DELTA_W'(r_ma.sy);
        end
    end

    // Stage C: classification and magnitudes.
    logic                     r_vc;
    t_meta                    r_mc;
    logic [Q_W-1:0]           r_adx, r_ady;
    logic [MAG_W-1:0]         r_ad0;
    logic [DEN_W-1:0]         r_denc;
    logic signed [DIST_W-1:0] n_eps;
    logic signed [DIFF_W-1:0] n_diff;
    logic [DIFF_W-1:0]        n_adiff;
    logic [DELTA_W-1:0]       n_adx, n_ady;
    logic [DIST_W-1:0]        n_ad0;
    t_meta                    n_mc;

    assign n_eps   = $signed({{(DIST_W - EPS_W - FRAC_N){1'b0}}, r_eps, {FRAC_N{1'b0}}});
    assign n_diff  = DIFF_W'(r_d0) - DIFF_W'(r_d1);
    assign n_adiff = n_diff[DIFF_W-1] ? DIFF_W'(-n_diff) : DIFF_W'(n_diff);
    assign n_adx   = r_dx[DELTA_W-1] ? DELTA_W'(-r_dx) : DELTA_W'(r_dx);
    assign n_ady   = r_dy[DELTA_W-1] ? DELTA_W'(-r_dy) : DELTA_W'(r_dy);
    assign n_ad0   = r_d0[DIST_W-1] ? DIST_W'(-r_d0) : DIST_W'(r_d0);

    always_comb begin
        n_mc = r_mb;
        if (r_d0 > n_eps) begin
            n_mc.s0 = SIDE_FRONT;
        end else if (r_d0 < -n_eps) begin
            n_mc.s0 = SIDE_BACK;
        end else begin
            n_mc.s0 = SIDE_ON;
        end
        if (r_d1 > n_eps) begin
            n_mc.s1 = SIDE_FRONT;
        end else if (r_d1 < -n_eps) begin
            n_mc.s1 = SIDE_BACK;
        end else begin
            n_mc.s1 = SIDE_ON;
        end
        n_mc.negx = r_dx[DELTA_W-1] ^ r_d0[DIST_W-1] ^ n_diff[DIFF_W-1];
        n_mc.negy = r_dy[DELTA_W-1] ^ r_d0[DIST_W-1] ^ n_diff[DIFF_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else if (adv) begin
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mc   <= n_mc;
            r_adx  <= n_adx[Q_W-1:0];
            r_ady  <= n_ady[Q_W-1:0];
            r_ad0  <= n_ad0;
            r_denc <= n_adiff[DEN_W-1:0];
        end
    end

    // Stage D: partial products of delta times distance.
    logic              r_vd;
    t_meta             r_md;
    logic [DEN_W-1:0]  r_dend;
    logic [PART_W-1:0] r_xlo, r_xhi, r_ylo, r_yhi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
        end else if (adv) begin
            r_vd <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_md   <= r_mc;
            r_dend <= r_denc;
            r_xlo  <= PART_W'(r_adx) * PART_W'(r_ad0[LO_W-1:0]);
            r_xhi  <= PART_W'(r_adx) * PART_W'(r_ad0[MAG_W-1:LO_W]);
            r_ylo  <= PART_W'(r_ady) * PART_W'(r_ad0[LO_W-1:0]);
            r_yhi  <= PART_W'(r_ady) * PART_W'(r_ad0[MAG_W-1:LO_W]);
        end
    end

    // Stage E and divider: one quotient bit per stage.
    logic             r_dv  [0:Q_W];
    t_meta            r_dm  [0:Q_W];
    logic [DEN_W-1:0] r_den [0:Q_W];
    logic [REM_W-1:0] r_rx  [0:Q_W];
    logic [REM_W-1:0] r_ry  [0:Q_W];
    logic [Q_W-1:0]   r_lx  [0:Q_W];
    logic [Q_W-1:0]   r_ly  [0:Q_W];
    logic [DVD_W-1:0] n_dvx, n_dvy;

    assign n_dvx = DVD_W'(r_xlo) + (DVD_W'(r_xhi) << LO_W);
    assign n_dvy = DVD_W'(r_ylo) + (DVD_W'(r_yhi) << LO_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (adv) begin
            r_dv[0] <= r_vd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dm[0]  <= r_md;
            r_den[0] <= r_dend;
            r_rx[0]  <= REM_W'(n_dvx[DVD_W-1:Q_W]);
            r_ry[0]  <= REM_W'(n_dvy[DVD_W-1:Q_W]);
            r_lx[0]  <= n_dvx[Q_W-1:0];
            r_ly[0]  <= n_dvy[Q_W-1:0];
        end
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_div
        logic [REM_W-1:0] n_tx, n_ty;
        logic             n_bx, n_by;

        assign n_tx = {r_rx[k-1][REM_W-2:0], r_lx[k-1][Q_W-1]};
        assign n_ty = {r_ry[k-1][REM_W-2:0], r_ly[k-1][Q_W-1]};
        assign n_bx = (n_tx >= REM_W'(r_den[k-1]));
        assign n_by = (n_ty >= REM_W'(r_den[k-1]));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k] <= 1'b0;
            end else if (adv) begin
                r_dv[k] <= r_dv[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dm[k]  <= r_dm[k-1];
                r_den[k] <= r_den[k-1];
                r_rx[k]  <= n_bx ? n_tx - REM_W'(r_den[k-1]) : n_tx;
                r_ry[k]  <= n_by ? n_ty - REM_W'(r_den[k-1]) : n_ty;
                r_lx[k]  <= {r_lx[k-1][Q_W-2:0], n_bx};
                r_ly[k]  <= {r_ly[k-1][Q_W-2:0], n_by};
            end
        end
    end

    // Output stage: split point, piece assembly.
    t_meta                       m;
    logic signed [COORD_W-1:0]   n_mx, n_my, n_negoff;
    logic signed [COORD_W+1:0]   n_ix, n_iy;
    logic [1:0]                  n_cls;
    logic                        n_hf, n_hb;
    logic signed [COORD_W-1:0]   n_f [0:3];
    logic signed [COORD_W-1:0]   n_b [0:3];

    assign m        = r_dm[Q_W];
    assign n_negoff = (m.off == COORD_MIN) ? COORD_MAX : -m.off;
    assign n_ix     = m.negx ? (COORD_W+2)'(m.sx) - (COORD_W+2)'(r_lx[Q_W])
                             : (COORD_W+2)'(m.sx) + (COORD_W+2)'(r_lx[Q_W]);
    assign n_iy     = m.negy ? (COORD_W+2)'(m.sy) - (COORD_W+2)'(r_ly[Q_W])
                             : (COORD_W+2)'(m.sy) + (COORD_W+2)'(r_ly[Q_W]);

    always_comb begin
        if (m.nx == NORM_ONE) begin
            n_mx = n_negoff;
        end else if (m.nx == NORM_MONE) begin
            n_mx = m.off;
        end else begin
            n_mx = n_ix[COORD_W-1:0];
        end
        if (m.ny == NORM_ONE) begin
            n_my = n_negoff;
        end else if (m.ny == NORM_MONE) begin
            n_my = m.off;
        end else begin
            n_my = n_iy[COORD_W-1:0];
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_f[i] = '0;
            n_b[i] = '0;
        end
        n_hf = 1'b0;
        n_hb = 1'b0;
        if (m.s0 == SIDE_ON && m.s1 == SIDE_ON) begin
            n_cls = CLS_ON;
        end else if (m.s0 != SIDE_BACK && m.s1 != SIDE_BACK) begin
            n_cls  = CLS_FRONT;
            n_hf   = 1'b1;
            n_f[0] = m.sx;
            n_f[1] = m.sy;
            n_f[2] = m.ex;
            n_f[3] = m.ey;
        end else if (m.s0 != SIDE_FRONT && m.s1 != SIDE_FRONT) begin
            n_cls  = CLS_BACK;
            n_hb   = 1'b1;
            n_b[0] = m.sx;
            n_b[1] = m.sy;
            n_b[2] = m.ex;
            n_b[3] = m.ey;
        end else begin
            n_cls = CLS_CROSS;
            n_hf  = 1'b1;
            n_hb  = 1'b1;
            if (m.s0 == SIDE_FRONT) begin
                n_f[0] = m.sx;
                n_f[1] = m.sy;
                n_f[2] = n_mx;
                n_f[3] = n_my;
                n_b[0] = n_mx;
                n_b[1] = n_my;
                n_b[2] = m.ex;
                n_b[3] = m.ey;
            end else begin
                n_b[0] = m.sx;
                n_b[1] = m.sy;
                n_b[2] = n_mx;
                n_b[3] = n_my;
                n_f[0] = n_mx;
                n_f[1] = n_my;
                n_f[2] = m.ex;
                n_f[3] = m.ey;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (adv) begin
            o_valid <= r_dv[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_segment_class <= n_cls;
            o_has_front     <= n_hf;
            o_has_back      <= n_hb;
            o_front_start_x <= n_f[0];
            o_front_start_y <= n_f[1];
            o_front_end_x   <= n_f[2];
            o_front_end_y   <= n_f[3];
            o_back_start_x  <= n_b[0];
            o_back_start_y  <= n_b[1];
            o_back_end_x    <= n_b[2];
            o_back_end_y    <= n_b[3];
        end
    end

endmodule
